// ===== rtl/rhc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared types, constants and the restoring-division step for the RGB to HSV
// converter core.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned CHAN_W            = 8;
  localparam int unsigned IN_DATA_W         = 4 * CHAN_W;
  localparam int unsigned HUE_FRAC_BITS_DEF = 6;
  localparam int unsigned SAT_FRAC_BITS_DEF = 12;
  localparam int unsigned HUE_INT_BITS      = 9;
  localparam int unsigned HUE_Q_INT_BITS    = 6;
  localparam int unsigned DEG_GREEN         = 120;
  localparam int unsigned DEG_BLUE          = 240;
  localparam int unsigned DEG_FULL          = 360;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_e;

  typedef struct packed {
    sector_e             sector;
    logic                neg;
    logic [CHAN_W-1:0]   brightness;
    logic [CHAN_W-1:0]   alpha;
  } side_t;

  // one restoring step: returns {quotient bit, new remainder}
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W:0]   trial,
                                               input logic [CHAN_W-1:0] divisor);
    logic [CHAN_W:0] diff;
    logic [CHAN_W:0] res;
    diff = trial - {1'b0, divisor};
    if (trial >= {1'b0, divisor}) begin
      res = {1'b1, diff[CHAN_W-1:0]};
    end else begin
      res = {1'b0, trial[CHAN_W-1:0]};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/rhc_prep.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_prep
// Input stage: max, min, delta, hue sector and the two dividends and divisors
// that seed the division chain.
// ----------------------------------------------------------------------------
module rhc_prep #(
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int unsigned SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF,
  parameter int unsigned STEPS         = 13
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [rhc_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [STEPS+rhc_pkg::CHAN_W-1:0]    hue_rd_o,
  output logic [rhc_pkg::CHAN_W-1:0]          hue_div_o,
  output logic [STEPS+rhc_pkg::CHAN_W-1:0]    sat_rd_o,
  output logic [rhc_pkg::CHAN_W-1:0]          sat_div_o,
  output rhc_pkg::side_t                      side_o
);

  localparam int unsigned CW = rhc_pkg::CHAN_W;
  localparam int unsigned LW = STEPS + CW;
  localparam int unsigned NW = CW + 6;

  logic [CW-1:0] red, green, blue, alpha;
  logic [CW-1:0] mx, mn, delta;
  logic [CW:0]   diff, abs_full;
  logic [NW-1:0] num60;
  rhc_pkg::sector_e sector;

  logic          valid_q;
  logic [LW-1:0] hue_rd_q, hue_rd_d, sat_rd_q, sat_rd_d;
  logic [CW-1:0] hue_div_q, hue_div_d, sat_div_q, sat_div_d;
  rhc_pkg::side_t side_q, side_d;

  assign red   = in_data_i[CW-1:0];
  assign green = in_data_i[2*CW-1:CW];
  assign blue  = in_data_i[3*CW-1:2*CW];
  assign alpha = in_data_i[4*CW-1:3*CW];

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;

    if (mx == red) begin
      sector = rhc_pkg::SECT_RED;
      diff   = {1'b0, green} - {1'b0, blue};
    end else if (mx == green) begin
      sector = rhc_pkg::SECT_GREEN;
      diff   = {1'b0, blue} - {1'b0, red};
    end else begin
      sector = rhc_pkg::SECT_BLUE;
      diff   = {1'b0, red} - {1'b0, green};
    end
    abs_full = diff[CW] ? (~diff + 1'b1) : diff;
    // times 60 as 64 - 4
    num60 = (NW'(abs_full[CW-1:0]) << 6) - (NW'(abs_full[CW-1:0]) << 2);

    hue_rd_d  = LW'(num60) << HUE_FRAC_BITS;
    sat_rd_d  = LW'(delta) << SAT_FRAC_BITS;
    hue_div_d = (delta == '0) ? CW'(1) : delta;
    sat_div_d = (mx == '0) ? CW'(1) : mx;
    side_d.sector     = sector;
    side_d.neg        = diff[CW];
    side_d.brightness = mx;
    side_d.alpha      = alpha;
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hue_rd_q  <= hue_rd_d;
      sat_rd_q  <= sat_rd_d;
      hue_div_q <= hue_div_d;
      sat_div_q <= sat_div_d;
      side_q    <= side_d;
    end
  end

  assign out_valid_o = valid_q;
  assign hue_rd_o    = hue_rd_q;
  assign hue_div_o   = hue_div_q;
  assign sat_rd_o    = sat_rd_q;
  assign sat_div_o   = sat_div_q;
  assign side_o      = side_q;

endmodule
`default_nettype wire

// ===== rtl/rhc_div_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_div_cell
// One cell of the division chain: one restoring step for the hue lane and one
// for the saturation lane, registered, with its own valid/ready.
// ----------------------------------------------------------------------------
module rhc_div_cell #(
  parameter int unsigned STEPS = 13
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic [STEPS+rhc_pkg::CHAN_W-1:0] hue_rd_i,
  input  wire logic [rhc_pkg::CHAN_W-1:0]   hue_div_i,
  input  wire logic [STEPS+rhc_pkg::CHAN_W-1:0] sat_rd_i,
  input  wire logic [rhc_pkg::CHAN_W-1:0]   sat_div_i,
  input  wire rhc_pkg::side_t               side_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [STEPS+rhc_pkg::CHAN_W-1:0]  hue_rd_o,
  output logic [rhc_pkg::CHAN_W-1:0]        hue_div_o,
  output logic [STEPS+rhc_pkg::CHAN_W-1:0]  sat_rd_o,
  output logic [rhc_pkg::CHAN_W-1:0]        sat_div_o,
  output rhc_pkg::side_t                    side_o
);

  localparam int unsigned CW = rhc_pkg::CHAN_W;
  localparam int unsigned LW = STEPS + CW;

  logic [CW:0]   hue_res, sat_res;
  logic [LW-1:0] hue_rd_d, hue_rd_q, sat_rd_d, sat_rd_q;
  logic [CW-1:0] hue_div_q, sat_div_q;
  rhc_pkg::side_t side_q;
  logic          valid_q;

  // lane word is {remainder, dividend bits shifting out / quotient bits in}
  always_comb begin
    hue_res  = rhc_pkg::div_step({hue_rd_i[LW-1:STEPS], hue_rd_i[STEPS-1]}, hue_div_i);
    sat_res  = rhc_pkg::div_step({sat_rd_i[LW-1:STEPS], sat_rd_i[STEPS-1]}, sat_div_i);
    hue_rd_d = {hue_res[CW-1:0], hue_rd_i[STEPS-2:0], hue_res[CW]};
    sat_rd_d = {sat_res[CW-1:0], sat_rd_i[STEPS-2:0], sat_res[CW]};
  end

  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hue_rd_q  <= hue_rd_d;
      sat_rd_q  <= sat_rd_d;
      hue_div_q <= hue_div_i;
      sat_div_q <= sat_div_i;
      side_q    <= side_i;
    end
  end

  assign out_valid_o = valid_q;
  assign hue_rd_o    = hue_rd_q;
  assign hue_div_o   = hue_div_q;
  assign sat_rd_o    = sat_rd_q;
  assign sat_div_o   = sat_div_q;
  assign side_o      = side_q;

  a_hue_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (hue_rd_q[LW-1:STEPS] < hue_div_q))
    else $error("hue remainder not below divisor");

  a_sat_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (sat_rd_q[LW-1:STEPS] < sat_div_q))
    else $error("saturation remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (hue_div_q != '0 && sat_div_q != '0))
    else $error("zero divisor in chain");

endmodule
`default_nettype wire

// ===== rtl/rhc_post.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_post
// Output stage: sector offset, sign and wrap of the hue, field packing and
// the output register.
// ----------------------------------------------------------------------------
module rhc_post #(
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int unsigned SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF,
  parameter int unsigned STEPS         = 13,
  parameter int unsigned OUT_W         = 48
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [STEPS+rhc_pkg::CHAN_W-1:0] hue_rd_i,
  input  wire logic [STEPS+rhc_pkg::CHAN_W-1:0] sat_rd_i,
  input  wire rhc_pkg::side_t                side_i,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [OUT_W-1:0]                   m_axis_tdata
);

  localparam int unsigned CW = rhc_pkg::CHAN_W;
  localparam int unsigned HW = HUE_FRAC_BITS + rhc_pkg::HUE_INT_BITS;
  localparam int unsigned QW = HUE_FRAC_BITS + rhc_pkg::HUE_Q_INT_BITS;
  localparam int unsigned SW = SAT_FRAC_BITS + 1;

  logic [HW-1:0] offset;
  logic          hue_up;
  logic [HW:0]   sum;
  logic [HW-1:0] hue_d, hue_q;
  logic [SW-1:0] sat_q;
  logic [CW-1:0] bright_q, alpha_q;
  logic          valid_q;

  always_comb begin
    case (side_i.sector)
      rhc_pkg::SECT_GREEN: offset = HW'(rhc_pkg::DEG_GREEN) << HUE_FRAC_BITS;
      rhc_pkg::SECT_BLUE:  offset = HW'(rhc_pkg::DEG_BLUE) << HUE_FRAC_BITS;
      default:             offset = '0;
    endcase
    // below a green or blue offset the fraction rounds up to the next step
    hue_up = side_i.neg && (side_i.sector != rhc_pkg::SECT_RED) &&
             (hue_rd_i[STEPS+CW-1:STEPS] != '0);
    if (side_i.neg) begin
      sum = {1'b0, offset} - (HW+1)'(hue_rd_i[QW-1:0]) - (HW+1)'(hue_up);
    end else begin
      sum = {1'b0, offset} + (HW+1)'(hue_rd_i[QW-1:0]);
    end
    hue_d = sum[HW] ? (sum[HW-1:0] + (HW'(rhc_pkg::DEG_FULL) << HUE_FRAC_BITS))
                    : sum[HW-1:0];
  end

  assign in_ready_o = !valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      hue_q    <= hue_d;
      sat_q    <= sat_rd_i[SW-1:0];
      bright_q <= side_i.brightness;
      alpha_q  <= side_i.alpha;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = OUT_W'({alpha_q, bright_q, sat_q, hue_q});

  a_hue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (hue_q < (HW'(rhc_pkg::DEG_FULL) << HUE_FRAC_BITS)))
    else $error("hue out of range");

  a_sat_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (sat_q <= (SW'(1) << SAT_FRAC_BITS)))
    else $error("saturation above one");

  a_grey_hue_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && sat_q == '0) |-> (hue_q == '0))
    else $error("grey pixel with nonzero hue");

endmodule
`default_nettype wire

// ===== rtl/rgb_to_hsv_converter_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_core
// RGBA pixel to fixed-point HSV with alpha passed through; a row of
// restoring-division cells computes hue and saturation side by side.
// ----------------------------------------------------------------------------
// Channel   Dir  Fields (low bit up)
// s_axis    in   red_in[7:0] green_in[7:0] blue_in[7:0] alpha_in[7:0]
// m_axis    out  hue[HUE_FRAC_BITS+8:0] saturation[SAT_FRAC_BITS:0]
//                brightness[7:0] alpha_out[7:0], zero padded to bytes
//
// One pixel per cycle sustained while m_axis_tready is high. STEPS is
// max(HUE_FRAC_BITS+6, SAT_FRAC_BITS+1), one division cell per quotient bit;
// a pixel passes the prep register, the STEPS cell registers and the output register.
// Reset clears only the valid flags of every stage.
// Each stage has its own ready, so bubbles close up behind a stalled output.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_core #(
  parameter int unsigned HUE_FRAC_BITS = rhc_pkg::HUE_FRAC_BITS_DEF,
  parameter int unsigned SAT_FRAC_BITS = rhc_pkg::SAT_FRAC_BITS_DEF,
  localparam int unsigned OUT_W = ((HUE_FRAC_BITS + rhc_pkg::HUE_INT_BITS +
                                    SAT_FRAC_BITS + 1 + 2 * rhc_pkg::CHAN_W + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // red_in, green_in, blue_in, alpha_in
  input  wire logic [rhc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // hue, saturation, brightness, alpha_out
  output logic [OUT_W-1:0]                   m_axis_tdata
);

  localparam int unsigned HQ    = HUE_FRAC_BITS + rhc_pkg::HUE_Q_INT_BITS;
  localparam int unsigned SQ    = SAT_FRAC_BITS + 1;
  localparam int unsigned STEPS = (HQ > SQ) ? HQ : SQ;
  localparam int unsigned CW    = rhc_pkg::CHAN_W;
  localparam int unsigned LW    = STEPS + CW;

  logic           valid [STEPS+1];
  logic           ready [STEPS+1];
  logic [LW-1:0]  hue_rd [STEPS+1];
  logic [LW-1:0]  sat_rd [STEPS+1];
  logic [CW-1:0]  hue_div [STEPS+1];
  logic [CW-1:0]  sat_div [STEPS+1];
  rhc_pkg::side_t side [STEPS+1];

  rhc_prep #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_FRAC_BITS(SAT_FRAC_BITS),
    .STEPS        (STEPS)
  ) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .out_valid_o(valid[0]),
    .out_ready_i(ready[0]),
    .hue_rd_o   (hue_rd[0]),
    .hue_div_o  (hue_div[0]),
    .sat_rd_o   (sat_rd[0]),
    .sat_div_o  (sat_div[0]),
    .side_o     (side[0])
  );

  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    rhc_div_cell #(
      .STEPS(STEPS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .in_valid_i (valid[i]),
      .in_ready_o (ready[i]),
      .hue_rd_i   (hue_rd[i]),
      .hue_div_i  (hue_div[i]),
      .sat_rd_i   (sat_rd[i]),
      .sat_div_i  (sat_div[i]),
      .side_i     (side[i]),
      .out_valid_o(valid[i+1]),
      .out_ready_i(ready[i+1]),
      .hue_rd_o   (hue_rd[i+1]),
      .hue_div_o  (hue_div[i+1]),
      .sat_rd_o   (sat_rd[i+1]),
      .sat_div_o  (sat_div[i+1]),
      .side_o     (side[i+1])
    );
  end

  rhc_post #(
    .HUE_FRAC_BITS(HUE_FRAC_BITS),
    .SAT_FRAC_BITS(SAT_FRAC_BITS),
    .STEPS        (STEPS),
    .OUT_W        (OUT_W)
  ) u_post (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (valid[STEPS]),
    .in_ready_o   (ready[STEPS]),
    .hue_rd_i     (hue_rd[STEPS]),
    .sat_rd_i     (sat_rd[STEPS]),
    .side_i       (side[STEPS]),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

endmodule
`default_nettype wire
